// ===== src/eesp_pkg.sv =====
package eesp_pkg;

  localparam int MaxVertices = 1024;
  localparam int MaxEdges    = 4096;
  localparam int PairCount   = 2 * MaxVertices;
  localparam int VtxW        = 10;
  localparam int PairW       = 11;
  localparam int EdgeAw      = 12;
  localparam int EdgeCntW    = 13;
  localparam int CfgW        = 11;
  localparam int DistW       = 32;

  localparam logic [DistW-1:0] DistInf = 32'hFFFF_FFFF;
  localparam logic [DistW-1:0] DistMax = 32'hFFFF_FFFE;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegVertexCount = 2'd0;
  localparam logic [1:0] RegSource      = 2'd1;
  localparam logic [1:0] RegTarget      = 2'd2;

  typedef struct packed {
    logic [VtxW-1:0] from_vertex;
    logic [VtxW-1:0] to_vertex;
    logic [15:0]     edge_weight;
    logic            last_edge;
  } req_t;

  typedef struct packed {
    logic             path_found;
    logic [DistW-1:0] distance;
  } rsp_t;

  typedef struct packed {
    logic [VtxW-1:0] from_vertex;
    logic [VtxW-1:0] to_vertex;
    logic [15:0]     edge_weight;
  } edge_t;

endpackage

// ===== src/even_edge_shortest_path.sv =====
// Channel  | Direction | Handshake         | Payload
// request  | in        | start_i / busy_o  | req_i (eesp_pkg::req_t)
// result   | out       | done_o strobe     | rsp_o (eesp_pkg::rsp_t)
// config   | in        | cfg_we_i          | cfg_idx_i, cfg_data_i
//
// An entry without last_edge is stored while the store has room, and busy_o stays low.
// A last_edge entry starts a search: a clearing pass over the whole distance store, then
// per settled pair a scan of all pairs, a pick and a scan of all edges, stalled once per
// back-to-back relax of one pair. A bad source or target goes straight to output after
// the clear; else a final scan and pick, reads of the target entry and the output end it.
// Reset clears control state and the edge count; the distance store is cleared per run.
module even_edge_shortest_path (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  eesp_pkg::req_t          req_i,
  output logic                    done_o,
  output eesp_pkg::rsp_t          rsp_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [eesp_pkg::CfgW-1:0] cfg_data_i
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StClear = 7'b0000010,
    StScan  = 7'b0000100,
    StPick  = 7'b0001000,
    StRelax = 7'b0010000,
    StFin   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [eesp_pkg::CfgW-1:0] vcount_q;
  logic [eesp_pkg::VtxW-1:0] src_q, tgt_q;
  logic [eesp_pkg::EdgeCntW-1:0] ecnt_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= eesp_pkg::CfgW'(2);
      src_q    <= '0;
      tgt_q    <= eesp_pkg::VtxW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        eesp_pkg::RegVertexCount: vcount_q <= cfg_data_i;
        eesp_pkg::RegSource:      src_q <= cfg_data_i[eesp_pkg::VtxW-1:0];
        eesp_pkg::RegTarget:      tgt_q <= cfg_data_i[eesp_pkg::VtxW-1:0];
        default: ;
      endcase
    end
  end

  // Clamped vertex count and pair count.
  logic [eesp_pkg::CfgW-1:0] n_eff;
  logic [eesp_pkg::CfgW:0]   pairs;
  always_comb begin
    n_eff = vcount_q;
    if (vcount_q > eesp_pkg::CfgW'(eesp_pkg::MaxVertices)) begin
      n_eff = eesp_pkg::CfgW'(eesp_pkg::MaxVertices);
    end
    if (vcount_q < eesp_pkg::CfgW'(2)) n_eff = eesp_pkg::CfgW'(2);
    pairs = {n_eff, 1'b0};
  end

  logic src_ok, tgt_ok;
  assign src_ok = {1'b0, src_q} < n_eff;
  assign tgt_ok = {1'b0, tgt_q} < n_eff;

  // Edge store: one write port, one registered read port.
  eesp_pkg::edge_t edge_mem [eesp_pkg::MaxEdges];
  eesp_pkg::edge_t edge_rd_q;
  logic [eesp_pkg::EdgeAw-1:0] edge_ra;
  logic accept, store_wr;
  assign accept   = start_i && !busy_o;
  assign store_wr = accept && (ecnt_q < eesp_pkg::EdgeCntW'(eesp_pkg::MaxEdges));

  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      edge_mem[ecnt_q[eesp_pkg::EdgeAw-1:0]] <= '{req_i.from_vertex, req_i.to_vertex,
                                                  req_i.edge_weight};
    end
    edge_rd_q <= edge_mem[edge_ra];
  end

  // Distance store with settled flag in bit 32: one write, one registered read.
  logic [eesp_pkg::DistW:0] dist_mem [eesp_pkg::PairCount];
  logic [eesp_pkg::DistW:0] dist_rd_q;
  logic [eesp_pkg::PairW-1:0] dist_ra, dist_wa;
  logic [eesp_pkg::DistW:0]   dist_wd;
  logic dist_we;
  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    dist_rd_q <= dist_mem[dist_ra];
  end

  // Sequencer counters and datapath registers.
  logic [eesp_pkg::PairW:0]    idx_q, idx_d;   // pair or clear index
  logic [eesp_pkg::EdgeCntW:0] eidx_q, eidx_d; // edge index, read pipelined
  logic [eesp_pkg::PairW-1:0]  rdidx_q, rdidx_d;
  logic                        rdv_q, rdv_d;
  logic [eesp_pkg::DistW-1:0]  pick_d_q, pick_d_d;
  logic [eesp_pkg::PairW:0]    pick_q, pick_d;
  logic                        erdv_q, erdv_d;
  logic                        done_q, done_d;
  eesp_pkg::rsp_t rsp_q, rsp_d;
  logic [eesp_pkg::EdgeCntW-1:0] ecnt_d;

  // Relax stage: after edge read, read the destination pair.
  logic [eesp_pkg::PairW-1:0] dst_q, dst_d;
  logic [eesp_pkg::DistW-1:0] cand_q, cand_d;
  logic                       rlx_q, rlx_d;

  logic [eesp_pkg::DistW:0] sum;
  assign sum = {1'b0, pick_d_q} + {17'd0, edge_rd_q.edge_weight};

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    eidx_d   = eidx_q;
    rdidx_d  = rdidx_q;
    rdv_d    = 1'b0;
    pick_d_d = pick_d_q;
    pick_d   = pick_q;
    erdv_d   = 1'b0;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    ecnt_d   = ecnt_q;
    dst_d    = dst_q;
    cand_d   = cand_q;
    rlx_d    = 1'b0;
    dist_we  = 1'b0;
    dist_wa  = '0;
    dist_wd  = '0;
    dist_ra  = '0;
    edge_ra  = eidx_q[eesp_pkg::EdgeAw-1:0];

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (store_wr) ecnt_d = ecnt_q + 1'b1;
          if (req_i.last_edge) begin
            idx_d   = '0;
            state_d = StClear;
          end
        end
      end
      // Sweep every entry back to infinity and unsettled; the source's even pair starts at zero.
      StClear: begin
        dist_we = 1'b1;
        dist_wa = idx_q[eesp_pkg::PairW-1:0];
        dist_wd = {1'b0, eesp_pkg::DistInf};
        if (idx_q[eesp_pkg::PairW-1:0] == {src_q, 1'b0}) dist_wd = '0;
        idx_d = idx_q + 1'b1;
        if (idx_q == (eesp_pkg::PairW+1)'(eesp_pkg::PairCount - 1)) begin
          if (!src_ok || !tgt_ok) begin
            rsp_d   = '{1'b0, eesp_pkg::DistInf};
            state_d = StOut;
          end else begin
            idx_d    = '0;
            pick_d_d = eesp_pkg::DistInf;
            pick_d   = pairs;
            state_d  = StScan;
          end
        end
      end
      // Minimum search over unsettled pairs, one read per cycle.
      StScan: begin
        dist_ra = idx_q[eesp_pkg::PairW-1:0];
        if (idx_q < pairs) begin
          rdv_d   = 1'b1;
          rdidx_d = idx_q[eesp_pkg::PairW-1:0];
          idx_d   = idx_q + 1'b1;
        end
        if (rdv_q && !dist_rd_q[eesp_pkg::DistW] &&
            dist_rd_q[eesp_pkg::DistW-1:0] < pick_d_q) begin
          pick_d_d = dist_rd_q[eesp_pkg::DistW-1:0];
          pick_d   = {1'b0, rdidx_q};
        end
        if (idx_q >= pairs && !rdv_q) state_d = StPick;
      end
      StPick: begin
        if (pick_q >= pairs) begin
          idx_d   = '0;
          state_d = StFin;
        end else begin
          dist_we = 1'b1;
          dist_wa = pick_q[eesp_pkg::PairW-1:0];
          dist_wd = {1'b1, pick_d_q};
          eidx_d  = '0;
          state_d = StRelax;
        end
      end
      // Edge scan: read edge, then read destination, then update.
      StRelax: begin
        edge_ra = eidx_q[eesp_pkg::EdgeAw-1:0];
        if (eidx_q < {1'b0, ecnt_q}) begin
          erdv_d = 1'b1;
          eidx_d = eidx_q + 1'b1;
        end
        if (erdv_q && edge_rd_q.from_vertex == pick_q[eesp_pkg::PairW-1:1] &&
            {1'b0, edge_rd_q.to_vertex} < n_eff) begin
          rlx_d  = 1'b1;
          dst_d  = {edge_rd_q.to_vertex, ~pick_q[0]};
          cand_d = sum > {1'b0, eesp_pkg::DistMax} ? eesp_pkg::DistMax
                                                   : sum[eesp_pkg::DistW-1:0];
        end
        dist_ra = dst_d;
        // Read-modify-write; a repeat of the same pair is held back below.
        if (rlx_q) begin
          if (cand_q < dist_rd_q[eesp_pkg::DistW-1:0]) begin
            dist_we = 1'b1;
            dist_wa = dst_q;
            dist_wd = {dist_rd_q[eesp_pkg::DistW], cand_q};
          end
        end
        if (eidx_q >= {1'b0, ecnt_q} && !erdv_q && !rlx_q) begin
          idx_d    = '0;
          pick_d_d = eesp_pkg::DistInf;
          pick_d   = pairs;
          state_d  = StScan;
        end
        if (rlx_d && rlx_q && dst_d == dst_q) begin
          // Back-to-back relax of one pair: stall the pipeline and re-read the same edge.
          rlx_d  = 1'b0;
          erdv_d = 1'b1;
          eidx_d = eidx_q;
          edge_ra = eidx_q[eesp_pkg::EdgeAw-1:0] - 1'b1;
        end
      end
      StFin: begin
        dist_ra = {tgt_q, 1'b0};
        idx_d   = idx_q + 1'b1;
        if (idx_q[0]) begin
          rsp_d   = '{dist_rd_q[eesp_pkg::DistW-1:0] != eesp_pkg::DistInf,
                      dist_rd_q[eesp_pkg::DistW-1:0]};
          state_d = StOut;
        end
      end
      StOut: begin
        done_d  = 1'b1;
        ecnt_d  = '0;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ecnt_q   <= '0;
      idx_q    <= '0;
      eidx_q   <= '0;
      rdv_q    <= 1'b0;
      erdv_q   <= 1'b0;
      rlx_q    <= 1'b0;
      done_q   <= 1'b0;
      pick_q   <= '0;
    end else begin
      state_q  <= state_d;
      ecnt_q   <= ecnt_d;
      idx_q    <= idx_d;
      eidx_q   <= eidx_d;
      rdv_q    <= rdv_d;
      erdv_q   <= erdv_d;
      rlx_q    <= rlx_d;
      done_q   <= done_d;
      pick_q   <= pick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rdidx_q  <= rdidx_d;
    pick_d_q <= pick_d_d;
    rsp_q    <= rsp_d;
    dst_q    <= dst_d;
    cand_q   <= cand_d;
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A result strobe only follows the output state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == StOut)) else $error("stray result strobe");
  // The edge count empties after every result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ecnt_q == '0) else $error("edge count not emptied");
  // The edge count never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecnt_q <= eesp_pkg::EdgeCntW'(eesp_pkg::MaxEdges)) else $error("edge count overflow");

endmodule
